FILE: src/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg: shared constants for the sprite transform blitter
// Draw mode codes, register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package stb_pkg;

  // parameter defaults
  localparam int MAX_SPRITE_DIM_DEF = 256;
  localparam int COORD_BITS_DEF     = 12;

  // fixed field widths
  localparam int COLOR_W    = 16;
  localparam int SIZE_W     = 9;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

  // draw modes
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KEYED  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SCALE2 = 3'd7;

  // register reset values
  localparam logic [SIZE_W-1:0] SPRITE_DIM_RST = 9'd16;
  localparam int                SCREEN_W_RST   = 320;
  localparam int                SCREEN_H_RST   = 240;

endpackage

FILE: src/sprite_transform_blitter.sv
// A pixel word passes the input stage register, then the result group register, before its results go out.
// Throughput: one pixel word per cycle while each pixel gives at most one result and the output accepts;
// in 2x scale mode the single output port sets the rate, and a pixel's results go out one at a time.
// Pixels that give no result put no word on the output stream.
// Reset: asynchronous, empties the pipeline, clears the counters, loads register defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_transform_blitter
// Maps a raster stream of sprite pixels to screen coordinates with flip,
// rotate, color key and 2x scale, clipping against the configured screen.
// ----------------------------------------------------------------------------
module sprite_transform_blitter
  import stb_pkg::*;
#(
  parameter int MAX_SPRITE_DIM = MAX_SPRITE_DIM_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [COLOR_W-1:0]    s_axis_tdata,  // pixel_color
  // screen write stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((2*(COORD_BITS-1)+COLOR_W+7)/8)*8-1:0]
                                m_axis_tdata,  // out_x, out_y, out_color, zero pad
  output logic                  m_axis_tlast   // run_last
);

  localparam int DIM_BITS  = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
  localparam int OFS_W     = DIM_BITS + 1;
  localparam int EXT_W     = (OFS_W > SIZE_W) ? OFS_W : SIZE_W;
  localparam int CALC_W    = ((COORD_BITS > DIM_BITS + 2) ? COORD_BITS : DIM_BITS + 2) + 1;
  localparam int OUT_W     = COORD_BITS - 1;
  localparam int TDATA_W   = ((2*OUT_W + COLOR_W + 7) / 8) * 8;
  localparam int SCR_LIMIT = 1 << (COORD_BITS - 1);
  localparam int SCR_W_RST = (SCREEN_W_RST > SCR_LIMIT) ? SCR_LIMIT : SCREEN_W_RST;
  localparam int SCR_H_RST = (SCREEN_H_RST > SCR_LIMIT) ? SCR_LIMIT : SCREEN_H_RST;

  // configuration registers
  logic [COORD_BITS-1:0] dest_x_q, dest_y_q;
  logic [SIZE_W-1:0]     sprite_w_q, sprite_h_q;
  logic [MODE_W-1:0]     mode_q;
  logic [COLOR_W-1:0]    key_q;
  logic [COORD_BITS-1:0] scr_w_q, scr_h_q;

  // source position counters
  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;

  // input stage
  logic                item_vld_q, item_vld_d;
  logic [COLOR_W-1:0]  item_color_q;
  logic [DIM_BITS-1:0] item_col_q, item_row_q;

  // result group stage: up to four screen positions
  logic [3:0]           mask_q, mask_d, mask_calc;
  logic [OUT_W-1:0]     slot_x_q [4];
  logic [OUT_W-1:0]     slot_y_q [4];
  logic [OUT_W-1:0]     slot_x_d [4];
  logic [OUT_W-1:0]     slot_y_d [4];
  logic [COLOR_W-1:0]   grp_color_q;

  logic s_accept, m_accept, grp_free, grp_load;
  logic [3:0] sel_oh;
  logic [EXT_W-1:0] w_ext, h_ext;
  logic [OFS_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic [COORD_BITS-1:0] scr_w_eff, scr_h_eff;
  logic [DIM_BITS-1:0] fi, fj;
  logic [OFS_W-1:0] ofs_x [4];
  logic [OFS_W-1:0] ofs_y [4];
  logic [CALC_W-1:0] pos_x [4];
  logic [CALC_W-1:0] pos_y [4];
  logic [OUT_W-1:0] out_x, out_y;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  // effective sprite and screen sizes
  always_comb begin
    w_ext = EXT_W'(sprite_w_q);
    h_ext = EXT_W'(sprite_h_q);
    if (w_ext == '0 || w_ext > EXT_W'(MAX_SPRITE_DIM)) begin
      w_ext = EXT_W'(MAX_SPRITE_DIM);
    end
    if (h_ext == '0 || h_ext > EXT_W'(MAX_SPRITE_DIM)) begin
      h_ext = EXT_W'(MAX_SPRITE_DIM);
    end
    w_eff = w_ext[OFS_W-1:0];
    h_eff = h_ext[OFS_W-1:0];
    scr_w_eff = (scr_w_q > COORD_BITS'(SCR_LIMIT)) ? COORD_BITS'(SCR_LIMIT) : scr_w_q;
    scr_h_eff = (scr_h_q > COORD_BITS'(SCR_LIMIT)) ? COORD_BITS'(SCR_LIMIT) : scr_h_q;
  end

  // raster counters, wrap at width and height, cleared by any config write
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    col_inc = {1'b0, col_q} + OFS_W'(1);
    row_inc = {1'b0, row_q} + OFS_W'(1);
    if (s_accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[DIM_BITS-1:0];
      end else begin
        col_d = col_inc[DIM_BITS-1:0];
      end
    end
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // config registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q   <= '0;
      dest_y_q   <= '0;
      sprite_w_q <= SPRITE_DIM_RST;
      sprite_h_q <= SPRITE_DIM_RST;
      mode_q     <= MODE_PLAIN;
      key_q      <= '0;
      scr_w_q    <= COORD_BITS'(SCR_W_RST);
      scr_h_q    <= COORD_BITS'(SCR_H_RST);
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DEST_X:   dest_x_q   <= cfg_data_i[COORD_BITS-1:0];
          REG_DEST_Y:   dest_y_q   <= cfg_data_i[COORD_BITS-1:0];
          REG_SPRITE_W: sprite_w_q <= cfg_data_i[SIZE_W-1:0];
          REG_SPRITE_H: sprite_h_q <= cfg_data_i[SIZE_W-1:0];
          REG_MODE:     mode_q     <= cfg_data_i[MODE_W-1:0];
          REG_KEY:      key_q      <= cfg_data_i[COLOR_W-1:0];
          REG_SCREEN_W: scr_w_q    <= cfg_data_i[COORD_BITS-1:0];
          REG_SCREEN_H: scr_h_q    <= cfg_data_i[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // handshake between the stages
  assign grp_free      = (mask_q == 4'b0000) || (m_accept && m_axis_tlast);
  assign grp_load      = item_vld_q && grp_free;
  assign s_axis_tready = !item_vld_q || grp_free;

  always_comb begin
    item_vld_d = item_vld_q;
    if (s_accept) begin
      item_vld_d = 1'b1;
    end else if (grp_load) begin
      item_vld_d = 1'b0;
    end
  end

  // input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_color_q <= s_axis_tdata;
      item_col_q   <= col_q;
      item_row_q   <= row_q;
    end
  end

  // mirrored source position
  always_comb begin
    logic [OFS_W-1:0] fi_w, fj_w;
    fi_w = w_eff - OFS_W'(1) - {1'b0, item_col_q};
    fj_w = h_eff - OFS_W'(1) - {1'b0, item_row_q};
    fi   = fi_w[DIM_BITS-1:0];
    fj   = fj_w[DIM_BITS-1:0];
  end

  // per-mode offsets from the sprite corner
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ofs_x[k] = {1'b0, item_col_q};
      ofs_y[k] = {1'b0, item_row_q};
    end
    case (mode_q)
      MODE_FLIP_H: ofs_x[0] = {1'b0, fi};
      MODE_FLIP_V: ofs_y[0] = {1'b0, fj};
      MODE_ROT90: begin
        ofs_x[0] = {1'b0, fj};
        ofs_y[0] = {1'b0, item_col_q};
      end
      MODE_ROT180: begin
        ofs_x[0] = {1'b0, fi};
        ofs_y[0] = {1'b0, fj};
      end
      MODE_ROT270: begin
        ofs_x[0] = {1'b0, item_row_q};
        ofs_y[0] = {1'b0, fi};
      end
      MODE_SCALE2: begin
        ofs_x[0] = {item_col_q, 1'b0};
        ofs_y[0] = {item_row_q, 1'b0};
        ofs_x[1] = {item_col_q, 1'b1};
        ofs_y[1] = {item_row_q, 1'b0};
        ofs_x[2] = {item_col_q, 1'b0};
        ofs_y[2] = {item_row_q, 1'b1};
        ofs_x[3] = {item_col_q, 1'b1};
        ofs_y[3] = {item_row_q, 1'b1};
      end
      default: ;
    endcase
  end

  // screen positions, clipping, color key and per-mode slot masks
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pos_x[k] = {{(CALC_W-COORD_BITS){dest_x_q[COORD_BITS-1]}}, dest_x_q}
               + {{(CALC_W-OFS_W){1'b0}}, ofs_x[k]};
      pos_y[k] = {{(CALC_W-COORD_BITS){dest_y_q[COORD_BITS-1]}}, dest_y_q}
               + {{(CALC_W-OFS_W){1'b0}}, ofs_y[k]};
      mask_calc[k] = !pos_x[k][CALC_W-1] && !pos_y[k][CALC_W-1]
                  && (pos_x[k] < CALC_W'(scr_w_eff))
                  && (pos_y[k] < CALC_W'(scr_h_eff));
      slot_x_d[k] = pos_x[k][OUT_W-1:0];
      slot_y_d[k] = pos_y[k][OUT_W-1:0];
    end
    case (mode_q)
      MODE_SCALE2: ;
      MODE_KEYED: begin
        mask_calc[3:1] = 3'b000;
        if (item_color_q == key_q) begin
          mask_calc[0] = 1'b0;
        end
      end
      default: mask_calc[3:1] = 3'b000;
    endcase
  end

  // lowest pending slot goes out first
  always_comb begin
    sel_oh = mask_q & (~mask_q + 4'd1);
    mask_d = mask_q;
    if (grp_load) begin
      mask_d = mask_calc;
    end else if (m_accept) begin
      mask_d = mask_q & ~sel_oh;
    end
  end

  // result group register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 4'b0000;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_load) begin
      grp_color_q <= item_color_q;
      for (int k = 0; k < 4; k++) begin
        slot_x_q[k] <= slot_x_d[k];
        slot_y_q[k] <= slot_y_d[k];
      end
    end
  end

  // output word select
  always_comb begin
    out_x = slot_x_q[0];
    out_y = slot_y_q[0];
    case (sel_oh)
      4'b0010: begin
        out_x = slot_x_q[1];
        out_y = slot_y_q[1];
      end
      4'b0100: begin
        out_x = slot_x_q[2];
        out_y = slot_y_q[2];
      end
      4'b1000: begin
        out_x = slot_x_q[3];
        out_y = slot_y_q[3];
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (mask_q != 4'b0000);
  assign m_axis_tlast  = ((mask_q & ~sel_oh) == 4'b0000);
  assign m_axis_tdata  = TDATA_W'({grp_color_q, out_y, out_x});

`ifndef SYNTHESIS
  // counters stay inside the configured sprite
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff))
    else $error("raster counter beyond sprite size");

  // only scale mode fills the extra slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_SCALE2) |-> (mask_q[3:1] == 3'b000))
    else $error("extra result slot outside scale mode");

  // a held input word is not lost while the result group is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !grp_free) |=> (item_vld_q && $stable(item_color_q)))
    else $error("input word dropped while results pending");
`endif

endmodule
